FILE: rtl/core/kwm_pkg.sv
// shared types and constants for the k-way sorted merge
// no dependencies; used by every module of the block
package kwm_pkg;

  localparam int LANES_DEF     = 8;
  localparam int DATA_BITS_DEF = 32;
  localparam int LANE_BITS     = 3;
  localparam int KIND_BITS     = 2;
  localparam int CFG_BITS      = 4;

  localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd8;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_MERGED = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  // operation that every cell of the sorted chain carries out
  typedef enum logic [2:0] {
    OP_HOLD       = 3'd0,
    OP_INSERT     = 3'd1,
    OP_POP        = 3'd2,
    OP_POP_INSERT = 3'd3,
    OP_CLEAR      = 3'd4
  } cell_op_t;

endpackage

FILE: rtl/core/k_way_sorted_merge.sv
// k-way sorted merge: takes one item per cycle, back to back, for as long as
// results drain. Pending lane heads sit in a chain of LANES cells kept in
// ascending order (ties to the lower lane); each cell does one compare
// against the incoming element per cycle, so the smallest head is always in
// the first cell and an item is decided in the cycle it is accepted. Its
// result is registered into a two-entry buffer on the way to the output;
// in_ready falls only while both entries are full. A write of lanes_in_use
// (0 acts as 1, values above LANES as LANES) starts a new merge.
// depends on kwm_pkg, kwm_cell and kwm_out_buf
module k_way_sorted_merge #(
  parameter int LANES     = kwm_pkg::LANES_DEF,
  parameter int DATA_BITS = kwm_pkg::DATA_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [kwm_pkg::CFG_BITS-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kwm_pkg::LANE_BITS-1:0] lane,
  input  logic [DATA_BITS-1:0]          value,
  input  logic                          end_mark,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kwm_pkg::KIND_BITS-1:0] kind,
  output logic [DATA_BITS-1:0]          merged_value,
  output logic [kwm_pkg::LANE_BITS-1:0] source_lane
);
  import kwm_pkg::*;

  logic [CFG_BITS-1:0]  lanes_in_use;
  logic [LANES-1:0]     full;
  logic [LANES-1:0]     full_next;
  logic [LANES-1:0]     fin;
  logic [LANES-1:0]     fin_next;

  logic [LANES-1:0]     lane_hot;
  logic [LANES-1:0]     best_hot;
  logic [LANES-1:0]     in_use;
  logic [LANES-1:0]     full_upd;
  logic [LANES-1:0]     fin_upd;
  logic                 accept;
  logic                 reject;
  logic                 waiting;

  cell_op_t             op;
  logic                 push;
  kind_t                res_kind;
  logic [DATA_BITS-1:0] res_value;
  logic [LANE_BITS-1:0] res_lane;

  logic                 c_valid [LANES];
  logic [DATA_BITS-1:0] c_value [LANES];
  logic [LANE_BITS-1:0] c_lane  [LANES];
  logic                 c_less  [LANES];

  assign accept = in_valid && in_ready;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_hot[i] = (32'(lane) == i);
      best_hot[i] = (32'(c_lane[0]) == i);
      in_use[i]   = (i == 0) || (32'(lanes_in_use) > i);
    end
  end

  always_comb begin
    reject   = !(|(lane_hot & in_use)) || (|(lane_hot & full)) || (|(lane_hot & fin));
    full_upd = end_mark ? full : (full | lane_hot);
    fin_upd  = end_mark ? (fin | lane_hot) : fin;
    // some lane in use still owes a head or an end mark
    waiting  = |(in_use & ~full_upd & ~fin_upd);
  end

  always_comb begin
    op        = OP_HOLD;
    push      = 1'b0;
    res_kind  = KIND_MERGED;
    res_value = '0;
    res_lane  = '0;
    full_next = full;
    fin_next  = fin;
    if (cfg_write) begin
      op        = OP_CLEAR;
      full_next = '0;
      fin_next  = '0;
    end else if (accept) begin
      push = 1'b1;
      if (reject) begin
        res_kind = KIND_REJECT;
        res_lane = lane;
      end else if (waiting) begin
        push      = 1'b0;
        op        = end_mark ? OP_HOLD : OP_INSERT;
        full_next = full_upd;
        fin_next  = fin_upd;
      end else if (end_mark) begin
        if (c_valid[0]) begin
          op        = OP_POP;
          res_value = c_value[0];
          res_lane  = c_lane[0];
          full_next = full_upd & ~best_hot;
          fin_next  = fin_upd;
        end else begin
          // every lane finished and drained
          op        = OP_CLEAR;
          res_kind  = KIND_DONE;
          full_next = '0;
          fin_next  = '0;
        end
      end else if (c_less[0]) begin
        // new element is the smallest: pass it straight through
        res_value = value;
        res_lane  = lane;
      end else begin
        op        = OP_POP_INSERT;
        res_value = c_value[0];
        res_lane  = c_lane[0];
        full_next = full_upd & ~best_hot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lanes_in_use <= CFG_RESET;
      full         <= '0;
      fin          <= '0;
    end else begin
      if (cfg_write) begin
        lanes_in_use <= cfg_data;
      end
      full <= full_next;
      fin  <= fin_next;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_cell
    logic                 p_valid;
    logic [DATA_BITS-1:0] p_value;
    logic [LANE_BITS-1:0] p_lane;
    logic                 p_less;
    logic                 n_valid;
    logic [DATA_BITS-1:0] n_value;
    logic [LANE_BITS-1:0] n_lane;
    logic                 n_less;

    if (g == 0) begin : g_first
      assign p_valid = 1'b0;
      assign p_value = '0;
      assign p_lane  = '0;
      assign p_less  = 1'b0;
    end else begin : g_mid_prev
      assign p_valid = c_valid[g-1];
      assign p_value = c_value[g-1];
      assign p_lane  = c_lane[g-1];
      assign p_less  = c_less[g-1];
    end

    if (g == LANES - 1) begin : g_last
      assign n_valid = 1'b0;
      assign n_value = '0;
      assign n_lane  = '0;
      assign n_less  = 1'b1;
    end else begin : g_mid_next
      assign n_valid = c_valid[g+1];
      assign n_value = c_value[g+1];
      assign n_lane  = c_lane[g+1];
      assign n_less  = c_less[g+1];
    end

    kwm_cell #(
      .DATA_BITS (DATA_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (op),
      .new_value  (value),
      .new_lane   (lane),
      .prev_valid (p_valid),
      .prev_value (p_value),
      .prev_lane  (p_lane),
      .prev_less  (p_less),
      .next_valid (n_valid),
      .next_value (n_value),
      .next_lane  (n_lane),
      .next_less  (n_less),
      .valid      (c_valid[g]),
      .value      (c_value[g]),
      .lane       (c_lane[g]),
      .less       (c_less[g])
    );
  end

  kwm_out_buf #(
    .DATA_BITS (DATA_BITS)
  ) u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_kind    (res_kind),
    .push_value   (res_value),
    .push_lane    (res_lane),
    .space        (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .merged_value (merged_value),
    .source_lane  (source_lane)
  );

endmodule

FILE: rtl/core/kwm_cell.sv
// one rank of the sorted head chain: holds one pending head and its lane
// depends on kwm_pkg; neighbours exchange contents and compare flags
module kwm_cell #(
  parameter int DATA_BITS = kwm_pkg::DATA_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  kwm_pkg::cell_op_t           op,
  input  logic [DATA_BITS-1:0]        new_value,
  input  logic [kwm_pkg::LANE_BITS-1:0] new_lane,
  input  logic                        prev_valid,
  input  logic [DATA_BITS-1:0]        prev_value,
  input  logic [kwm_pkg::LANE_BITS-1:0] prev_lane,
  input  logic                        prev_less,
  input  logic                        next_valid,
  input  logic [DATA_BITS-1:0]        next_value,
  input  logic [kwm_pkg::LANE_BITS-1:0] next_lane,
  input  logic                        next_less,
  output logic                        valid,
  output logic [DATA_BITS-1:0]        value,
  output logic [kwm_pkg::LANE_BITS-1:0] lane,
  output logic                        less
);
  import kwm_pkg::*;

  logic [DATA_BITS+LANE_BITS-1:0] new_key;
  logic [DATA_BITS+LANE_BITS-1:0] own_key;

  // sign bit flipped so an unsigned compare orders signed values; lane breaks ties
  assign new_key = {~new_value[DATA_BITS-1], new_value[DATA_BITS-2:0], new_lane};
  assign own_key = {~value[DATA_BITS-1], value[DATA_BITS-2:0], lane};
  // an empty rank sorts after everything
  assign less    = !valid || (new_key < own_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (op)
        OP_HOLD: begin
        end
        OP_INSERT: begin
          if (prev_less) begin
            valid <= prev_valid;
            value <= prev_value;
            lane  <= prev_lane;
          end else if (less) begin
            valid <= 1'b1;
            value <= new_value;
            lane  <= new_lane;
          end
        end
        OP_POP: begin
          valid <= next_valid;
          value <= next_value;
          lane  <= next_lane;
        end
        OP_POP_INSERT: begin
          if (!next_less) begin
            valid <= next_valid;
            value <= next_value;
            lane  <= next_lane;
          end else if (!less) begin
            valid <= 1'b1;
            value <= new_value;
            lane  <= new_lane;
          end
        end
        OP_CLEAR: begin
          valid <= 1'b0;
        end
        default: begin
          valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/kwm_out_buf.sv
// two-entry result buffer between the merge logic and the output channel
// depends on kwm_pkg; ready is taken from a register
module kwm_out_buf #(
  parameter int DATA_BITS = kwm_pkg::DATA_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [kwm_pkg::KIND_BITS-1:0] push_kind,
  input  logic [DATA_BITS-1:0]          push_value,
  input  logic [kwm_pkg::LANE_BITS-1:0] push_lane,
  output logic                          space,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kwm_pkg::KIND_BITS-1:0] kind,
  output logic [DATA_BITS-1:0]          merged_value,
  output logic [kwm_pkg::LANE_BITS-1:0] source_lane
);
  import kwm_pkg::*;

  logic                 skid_valid;
  logic [KIND_BITS-1:0] skid_kind;
  logic [DATA_BITS-1:0] skid_value;
  logic [LANE_BITS-1:0] skid_lane;
  logic                 out_free;

  assign space    = !skid_valid;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        kind         <= skid_kind;
        merged_value <= skid_value;
        source_lane  <= skid_lane;
        skid_kind    <= push_kind;
        skid_value   <= push_value;
        skid_lane    <= push_lane;
      end else begin
        kind         <= push_kind;
        merged_value <= push_value;
        source_lane  <= push_lane;
      end
    end else if (push) begin
      skid_kind  <= push_kind;
      skid_value <= push_value;
      skid_lane  <= push_lane;
    end
  end

endmodule

FILE: tb/tb_k_way_sorted_merge.sv
// testbench for k_way_sorted_merge: directed and random lane streams with idling and stalls
// holds a small class that tracks lane heads and the results they should produce
// depends on kwm_pkg and the k_way_sorted_merge rtl
`timescale 1ns / 1ps

module tb_k_way_sorted_merge;
  import kwm_pkg::*;

  localparam int DW          = DATA_BITS_DEF;
  localparam int NL          = LANES_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SEGMENTS    = 14;
  localparam int SEG_ITEMS   = 50;

  typedef struct packed {
    kind_t                kind;
    logic [DW-1:0]        val;
    logic [LANE_BITS-1:0] src;
  } merge_result_t;

  class heads_tracker;
    logic signed [DW-1:0] head_val[NL];
    bit                   head_full[NL];
    bit                   finished[NL];
    logic [CFG_BITS-1:0]  lanes_cfg;
    merge_result_t        due_results[$];
    int                   mismatches;
    int                   merges;

    function new();
      lanes_cfg  = CFG_RESET;
      mismatches = 0;
      merges     = 0;
      clear_heads();
    endfunction

    function void clear_heads();
      for (int i = 0; i < NL; i++) begin
        head_val[i]  = '0;
        head_full[i] = 1'b0;
        finished[i]  = 1'b0;
      end
      merges++;
    endfunction

    function int active_lanes();
      int n;
      n = int'(lanes_cfg);
      if (n == 0) n = 1;
      if (n > NL) n = NL;
      return n;
    endfunction

    function bit lane_open(int l);
      return !head_full[l] && !finished[l];
    endfunction

    function void set_lanes(logic [CFG_BITS-1:0] v);
      lanes_cfg = v;
      clear_heads();
    endfunction

    function void push(kind_t k, logic [DW-1:0] v, logic [LANE_BITS-1:0] l);
      merge_result_t r;
      r.kind = k;
      r.val  = v;
      r.src  = l;
      due_results = {due_results, r};
    endfunction

    // one accepted item: update heads and queue whatever it causes
    function void take_item(logic [LANE_BITS-1:0] l, logic [DW-1:0] v, logic e);
      int                   n;
      bit                   waiting;
      bit                   any_head;
      int                   best;
      logic signed [DW-1:0] best_v;
      n        = active_lanes();
      waiting  = 1'b0;
      any_head = 1'b0;
      best     = 0;
      best_v   = '0;
      if (l >= n || head_full[l] || finished[l]) begin
        push(KIND_REJECT, '0, l);
        return;
      end
      if (e) begin
        finished[l] = 1'b1;
      end else begin
        head_val[l]  = v;
        head_full[l] = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
        if (head_full[i]) begin
          // strict compare keeps ties on the lower lane
          if (!any_head || head_val[i] < best_v) begin
            best_v = head_val[i];
            best   = i;
          end
          any_head = 1'b1;
        end else if (!finished[i]) begin
          waiting = 1'b1;
        end
      end
      if (waiting) return;
      if (any_head) begin
        head_full[best] = 1'b0;
        push(KIND_MERGED, best_v, best[LANE_BITS-1:0]);
      end else begin
        clear_heads();
        push(KIND_DONE, '0, '0);
      end
    endfunction

    function void match_result(logic [KIND_BITS-1:0] k, logic [DW-1:0] v,
                               logic [LANE_BITS-1:0] l);
      merge_result_t w;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d value %0d lane %0d", k, $signed(v), l);
        return;
      end
      w = due_results.pop_front();
      if (k !== w.kind || v !== w.val || l !== w.src) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp kind %0d value %0d lane %0d, got kind %0d value %0d lane %0d",
                   w.kind, $signed(w.val), w.src, k, $signed(v), l);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_BITS-1:0]  cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [LANE_BITS-1:0] lane = '0;
  logic [DW-1:0]        value = '0;
  logic                 end_mark = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [KIND_BITS-1:0] kind;
  logic [DW-1:0]        merged_value;
  logic [LANE_BITS-1:0] source_lane;

  heads_tracker sb;
  int           idle_pct = 0;
  int           stall_pct = 0;
  int           hold_request = 0;
  int           hold_left = 0;
  int           cycles = 0;

  // per-lane stream state for well-formed merges
  int           seen_merges = -1;
  int           style;
  int           lane_left[NL];
  bit           started[NL];
  longint       lane_last[NL];
  longint       step_max;
  int           cfg_plan[SEGMENTS] = '{1, 8, 2, 5, 0, 15, 3, 7, 4, 6, 9, 8, 1, 12};

  k_way_sorted_merge uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .lane         (lane),
    .value        (value),
    .end_mark     (end_mark),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .merged_value (merged_value),
    .source_lane  (source_lane)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: checks results, stalls at random, and holds off when asked
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.match_result(kind, merged_value, source_lane);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_item(input logic [LANE_BITS-1:0] l, input logic [DW-1:0] v,
                           input logic e);
    in_valid <= 1'b1;
    lane     <= l;
    value    <= v;
    end_mark <= e;
    do @(posedge clk); while (!in_ready);
    sb.take_item(l, v, e);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic wait_drained();
    while (sb.due_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_lanes(input logic [CFG_BITS-1:0] v);
    in_valid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_lanes(v);
  endtask

  task automatic restart_streams();
    seen_merges = sb.merges;
    style = $urandom_range(2);
    case (style)
      0: step_max = 64'd1 << 26;
      1: step_max = 2;
      default: step_max = 64'd1 << 30;
    endcase
    for (int l = 0; l < NL; l++) begin
      lane_left[l] = $urandom_range(6);
      started[l]   = 1'b0;
      case (style)
        0: lane_last[l] = longint'(int'($urandom));
        1: lane_last[l] = longint'($urandom_range(16)) - 8;
        default: lane_last[l] = -64'sd2147483648;
      endcase
    end
  endtask

  // mostly the next element or end mark of an open lane, now and then noise
  task automatic send_stream_item();
    int     n;
    int     open_lanes[$];
    int     l;
    longint nv;
    if (seen_merges != sb.merges) restart_streams();
    if ($urandom_range(99) < 12) begin
      send_item(LANE_BITS'($urandom_range(NL - 1)), $urandom, $urandom_range(3) == 0);
      return;
    end
    n = sb.active_lanes();
    for (int i = 0; i < n; i++)
      if (sb.lane_open(i)) open_lanes = {open_lanes, i};
    l = open_lanes[$urandom_range(open_lanes.size() - 1)];
    if (lane_left[l] == 0) begin
      send_item(LANE_BITS'(l), $urandom, 1'b1);
    end else begin
      nv = lane_last[l];
      if (started[l]) nv = nv + longint'($urandom_range(0, int'(step_max)));
      if (nv > 64'sd2147483647) nv = 64'sd2147483647;
      lane_last[l] = nv;
      started[l]   = 1'b1;
      lane_left[l]--;
      send_item(LANE_BITS'(l), nv[DW-1:0], 1'b0);
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // three lanes: full, out of range, tie on the minimum, finished lane, done
    write_lanes(4'd3);
    send_item(3'd0, 32'h8000_0000, 1'b0);
    send_item(3'd0, 32'd7, 1'b0);
    send_item(3'd5, 32'd0, 1'b0);
    send_item(3'd1, 32'h7fff_ffff, 1'b0);
    send_item(3'd2, 32'h8000_0000, 1'b0);
    send_item(3'd0, 32'd1, 1'b1);
    send_item(3'd2, 32'd0, 1'b1);
    send_item(3'd0, 32'd3, 1'b0);
    send_item(3'd1, 32'd0, 1'b1);

    // zero acts as one lane
    write_lanes(4'd0);
    send_item(3'd0, 32'hffff_ffff, 1'b0);
    send_item(3'd1, 32'd5, 1'b0);
    send_item(3'd0, 32'd0, 1'b1);

    // above the lane count acts as all lanes; merge of nothing but end marks
    write_lanes(4'd15);
    send_item(3'd7, 32'd42, 1'b1);
    send_item(3'd7, 32'd1, 1'b0);
    for (int l = 0; l < NL - 1; l++) send_item(LANE_BITS'(l), 32'hffff_ffff, 1'b1);

    // a write in the middle of a merge throws the heads away
    write_lanes(4'd9);
    send_item(3'd2, 32'd10, 1'b0);
    write_lanes(4'd2);
    send_item(3'd2, 32'd10, 1'b0);
    send_item(3'd7, 32'h5a5a_a5a5, 1'b0);

    for (int s = 0; s < SEGMENTS; s++) begin
      if (s == SEGMENTS - 1) cfg_plan[s] = $urandom_range(15);
      write_lanes(CFG_BITS'(cfg_plan[s]));
      restart_streams();
      case (s % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      // long hold-off on the output while items keep coming
      if (s == 0) hold_request = 300;
      for (int i = 0; i < SEG_ITEMS; i++) begin
        if (s == 6 && i == SEG_ITEMS / 2) begin
          in_valid <= 1'b0;
          wait_drained();
          @(posedge clk);
        end
        send_stream_item();
      end
    end

    in_valid  <= 1'b0;
    stall_pct = 0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
